### sv/assert_macros.svh
// Assertion helpers shared by the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS);
    localparam int CELLS  = ROWS * COLUMNS;
    localparam int AW     = $clog2(CELLS);
    // compare width: holds COLUMNS, ROWS and any row/col input value plus one
    localparam int CMP_W  = 9;
    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [7:0]  BLANK_ATTR   = 8'h0F;
    localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [15:0] BLANK_CELL   = {BLANK_ATTR, BLANK_CHAR};

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_FILL,
        BK_READ
    } t_back_state;

    // One classified item, as the front hands it to the back.
    typedef struct packed {
        logic          do_write;
        logic          do_read;
        logic          rd_zero;
        logic          clr_all;
        logic          inv_row;
        logic [RW-1:0] inv_phys;
        logic [RW-1:0] phys_row;
        logic [CW-1:0] col;
        logic [15:0]   data;
        logic [4:0]    cur_row;
        logic [6:0]    cur_col;
        logic          scrolled;
    } t_cmd;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       scrolled;
    } t_result;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] pcol);
        return AW'(prow) * AW'(COLUMNS) + AW'(pcol);
    endfunction

endpackage

### sv/tcw_ram.sv
`timescale 1ns / 1ps
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### sv/tcw_front.sv
`timescale 1ns / 1ps
module tcw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_fifo_full,
    input  logic [1:0]    i_op,
    input  logic [7:0]    i_ch,
    input  logic [3:0]    i_fg,
    input  logic [3:0]    i_bg,
    input  logic [4:0]    i_row,
    input  logic [6:0]    i_col,
    output logic          o_cmd_push,
    output tcw_pkg::t_cmd o_cmd
);
    import tcw_pkg::*;

    logic [RW-1:0]    r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_base, n_base;
    logic [CMP_W-1:0] row_x, col_x, rd_sum, cur_sum, rcol_x;
    t_cmd             cmd;

    assign o_cmd_push = i_push && !i_fifo_full;
    assign o_cmd      = cmd;

    always_comb begin
        cmd    = '0;
        n_base = r_base;
        row_x  = CMP_W'(r_row);
        col_x  = CMP_W'(r_col);
        rcol_x = CMP_W'(i_col);
        // map logical rows onto the rotating physical rows
        rd_sum = CMP_W'(r_base) + CMP_W'(i_row);
        if (rd_sum >= CMP_W'(ROWS)) begin
            rd_sum = rd_sum - CMP_W'(ROWS);
        end
        cur_sum = CMP_W'(r_base) + CMP_W'(r_row);
        if (cur_sum >= CMP_W'(ROWS)) begin
            cur_sum = cur_sum - CMP_W'(ROWS);
        end
        case (t_op'(i_op))
            OP_PUT: begin
                if (i_ch == NEWLINE_CHAR) begin
                    col_x = '0;
                    row_x = row_x + 1'b1;
                end else begin
                    cmd.do_write = 1'b1;
                    cmd.phys_row = cur_sum[RW-1:0];
                    cmd.col      = r_col;
                    cmd.data     = {i_bg, i_fg, i_ch};
                    col_x        = col_x + 1'b1;
                end
                if (col_x >= CMP_W'(COLUMNS)) begin
                    col_x = '0;
                    row_x = row_x + 1'b1;
                end
                // scroll: the old top row becomes the new bottom row
                if (row_x >= CMP_W'(ROWS)) begin
                    row_x        = CMP_W'(ROWS - 1);
                    col_x        = '0;
                    cmd.inv_row  = 1'b1;
                    cmd.inv_phys = r_base;
                    cmd.scrolled = 1'b1;
                    n_base       = (r_base == RW'(ROWS - 1)) ? '0 : r_base + 1'b1;
                end
            end
            OP_CLEAR: begin
                cmd.clr_all = 1'b1;
                row_x       = '0;
                col_x       = '0;
            end
            OP_READ: begin
                cmd.do_read  = 1'b1;
                cmd.rd_zero  = (CMP_W'(i_row) >= CMP_W'(ROWS)) ||
                               (rcol_x >= CMP_W'(COLUMNS));
                cmd.phys_row = rd_sum[RW-1:0];
                cmd.col      = rcol_x[CW-1:0];
            end
            default: begin
            end
        endcase
        n_row       = row_x[RW-1:0];
        n_col       = col_x[CW-1:0];
        cmd.cur_row = row_x[4:0];
        cmd.cur_col = col_x[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_base <= '0;
        end else if (o_cmd_push) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_base <= n_base;
        end
    end

endmodule

### sv/tcw_cmd_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcw_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output tcw_pkg::t_cmd o_data,
    output logic          o_empty
);
    import tcw_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QPW-1:0] r_wptr, r_rptr;
    logic [QCW-1:0] r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")
    `ASSERT_CLK(a_count_hold, i_clk, i_rst_n, (i_push == i_pop) |=> $stable(r_count), "count moved")

endmodule

### sv/tcw_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  tcw_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output tcw_pkg::t_result o_result
);
    import tcw_pkg::*;

    t_back_state     r_state, n_state;
    t_cmd            r_cmd;
    logic [CW-1:0]   r_fill_col, n_fill_col;
    logic [ROWS-1:0] r_valid, n_valid;
    logic            r_out_valid;
    t_result         r_out, res;

    logic            w_finish, w_set_valid, w_row_ok;
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [15:0]     ram_wdata, ram_rdata;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_row_ok  = r_valid[r_cmd.phys_row];
    assign o_cmd_pop = (r_state == BK_IDLE) && i_cmd_valid && !r_out_valid;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (o_cmd_pop) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (r_cmd.do_write && !w_row_ok) begin
                    n_state = BK_FILL;
                end else if (r_cmd.do_read && !r_cmd.rd_zero && w_row_ok) begin
                    n_state = BK_READ;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_FILL: begin
                if (r_fill_col == CW'(COLUMNS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_READ: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = cell_addr(r_cmd.phys_row, r_cmd.col);
        ram_raddr      = cell_addr(r_cmd.phys_row, r_cmd.col);
        ram_wdata      = r_cmd.data;
        w_finish       = 1'b0;
        w_set_valid    = 1'b0;
        n_fill_col     = r_fill_col;
        res.cursor_row = r_cmd.cur_row;
        res.cursor_col = r_cmd.cur_col;
        res.cell_char  = '0;
        res.cell_attr  = '0;
        res.scrolled   = r_cmd.scrolled;
        case (r_state)
            BK_EXEC: begin
                n_fill_col = '0;
                if (r_cmd.do_write) begin
                    ram_we   = w_row_ok;
                    w_finish = w_row_ok;
                end else if (r_cmd.do_read && !r_cmd.rd_zero && w_row_ok) begin
                    ram_re = 1'b1;
                end else begin
                    w_finish = 1'b1;
                    // a blanked row reads as space on the default attribute
                    if (r_cmd.do_read && !r_cmd.rd_zero) begin
                        res.cell_char = BLANK_CHAR;
                        res.cell_attr = BLANK_ATTR;
                    end
                end
            end
            BK_FILL: begin
                ram_we     = 1'b1;
                ram_waddr  = cell_addr(r_cmd.phys_row, r_fill_col);
                ram_wdata  = (r_fill_col == r_cmd.col) ? r_cmd.data : BLANK_CELL;
                n_fill_col = r_fill_col + 1'b1;
                if (r_fill_col == CW'(COLUMNS - 1)) begin
                    w_finish    = 1'b1;
                    w_set_valid = 1'b1;
                end
            end
            BK_READ: begin
                w_finish      = 1'b1;
                res.cell_char = ram_rdata[7:0];
                res.cell_attr = ram_rdata[15:8];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (w_finish) begin
            if (w_set_valid) begin
                n_valid[r_cmd.phys_row] = 1'b1;
            end
            if (r_cmd.inv_row) begin
                n_valid[r_cmd.inv_phys] = 1'b0;
            end
            if (r_cmd.clr_all) begin
                n_valid = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_finish) begin
            r_out <= res;
        end
        r_fill_col <= n_fill_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_finish && r_out_valid, "result overwritten")
    `ASSERT_CLK(a_fill_start, i_clk, i_rst_n, (r_state == BK_FILL && $past(r_state) == BK_EXEC) |-> (r_fill_col == '0), "fill did not start at column zero")
    `ASSERT_CLK(a_read_valid_row, i_clk, i_rst_n, (r_state == BK_READ) |-> w_row_ok, "memory read of a blanked row")

endmodule

### sv/text_console_writer.sv
`timescale 1ns / 1ps
// Character-cell text console: a ROWS x COLUMNS grid of char/attribute cells and a cursor.
// Input channel (queue style): drive i_op/i_ch/i_fg/i_bg/i_row/i_col with i_push; the item
// is taken on a clock edge where i_push is high and o_full is low. Op 0 puts a character
// at the cursor (10 is newline), op 1 clears the screen, op 2 reads one cell.
// Result channel: while o_empty is low the oldest result sits on the o_ ports; it is taken
// on an edge where i_pop is high. Every item gives exactly one result, in order.
// After the accepting edge an item passes the command queue and the back-end execute
// state, and for a read also the memory-read state, before o_empty drops. The first put
// into a row that has been blanked (after reset, clear or scroll) rewrites that whole row,
// one cell a cycle, before its result appears. The back-end sequencer, which owns the
// single-write/single-read cell memory, takes a new item only when idle with no result
// waiting; the front and a 2-deep command queue keep taking items in the meantime.
// Scrolling rotates a row base instead of copying rows; per-row valid flops mark blanked
// rows, which read back as space on attribute 0x0F.
// Reset (synchronous, active low) homes the cursor and marks every row blank at once: no
// clearing pass is needed and items are taken from the first cycle after reset.
// A stalled result (i_pop low) holds the back end; the queue then fills and o_full rises.
module text_console_writer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [1:0] i_op,
    input  logic [7:0] i_ch,
    input  logic [3:0] i_fg,
    input  logic [3:0] i_bg,
    input  logic [4:0] i_row,
    input  logic [6:0] i_col,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [4:0] o_cursor_row,
    output logic [6:0] o_cursor_col,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_attr,
    output logic       o_scrolled
);
    import tcw_pkg::*;

    // classified item flowing from the front end through the queue
    t_cmd    front_cmd, queue_cmd;
    logic    front_push, queue_empty, queue_pop;
    t_result result;

    // front end: track the cursor and row base, classify each item
    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_fifo_full (o_full),
        .i_op        (i_op),
        .i_ch        (i_ch),
        .i_fg        (i_fg),
        .i_bg        (i_bg),
        .i_row       (i_row),
        .i_col       (i_col),
        .o_cmd_push  (front_push),
        .o_cmd       (front_cmd)
    );

    // hold classified items until the back end is free
    tcw_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (o_full),
        .i_pop   (queue_pop),
        .o_data  (queue_cmd),
        .o_empty (queue_empty)
    );

    // back end: carry out memory writes, row fills and reads; register the result
    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!queue_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (result)
    );

    assign o_cursor_row = result.cursor_row;
    assign o_cursor_col = result.cursor_col;
    assign o_cell_char  = result.cell_char;
    assign o_cell_attr  = result.cell_attr;
    assign o_scrolled   = result.scrolled;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
import tcw_pkg::*;

// One input item as it crosses the push side.
typedef struct packed {
    t_op        op;
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [4:0] row;
    logic [6:0] col;
} t_console_item;

function automatic t_console_item item_of(t_op op, logic [7:0] ch, logic [3:0] fg,
                                          logic [3:0] bg, logic [4:0] row, logic [6:0] col);
    t_console_item it;
    it.op  = op;
    it.ch  = ch;
    it.fg  = fg;
    it.bg  = bg;
    it.row = row;
    it.col = col;
    return it;
endfunction

// Console model plus the queue of results it has promised.
class console_scoreboard;
    logic [15:0] screen [CELLS];
    int unsigned cur_row;
    int unsigned cur_col;
    t_result     awaited_results [$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
        blank_screen();
        cur_row      = 0;
        cur_col      = 0;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function void blank_screen();
        foreach (screen[i]) screen[i] = BLANK_CELL;
    endfunction

    function int unsigned waiting();
        return awaited_results.size();
    endfunction

    // Advance the console by one accepted item and queue the result it owes.
    function void note_item(t_console_item it);
        t_result res;
        res = '0;
        case (it.op)
            OP_PUT: begin
                if (it.ch == NEWLINE_CHAR) begin
                    cur_col = 0;
                    cur_row++;
                end else begin
                    screen[cur_row * COLUMNS + cur_col] = {it.bg, it.fg, it.ch};
                    cur_col++;
                end
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                        screen[i] = screen[i + COLUMNS];
                    for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                        screen[i] = BLANK_CELL;
                    cur_row      = ROWS - 1;
                    cur_col      = 0;
                    res.scrolled = 1'b1;
                end
            end
            OP_CLEAR: begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            OP_READ: begin
                if (it.row < ROWS && it.col < COLUMNS) begin
                    res.cell_char = screen[int'(it.row) * COLUMNS + int'(it.col)][7:0];
                    res.cell_attr = screen[int'(it.row) * COLUMNS + int'(it.col)][15:8];
                end
            end
            default: ;
        endcase
        res.cursor_row = 5'(cur_row);
        res.cursor_col = 7'(cur_col);
        awaited_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Match one popped result against the oldest promised one.
    function void check_result(t_result got);
        t_result want;
        results_seen++;
        if (awaited_results.size() == 0) begin
            $error("result with no item outstanding: cursor %0d,%0d",
                   got.cursor_row, got.cursor_col);
            mismatches++;
            return;
        end
        want = awaited_results.pop_front();
        compare_field("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
        compare_field("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
        compare_field("cell_char", want.cell_char, got.cell_char);
        compare_field("cell_attr", want.cell_attr, got.cell_attr);
        compare_field("scrolled", 8'(want.scrolled), 8'(got.scrolled));
    endfunction
endclass

module tb;
    // Generous bound on the length of the run.
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1750;
    // Long receiver hold-off, long enough to back the queue up into o_full.
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AFTER = 300;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_push  = 1'b0;
    logic [1:0] i_op    = OP_PUT;
    logic [7:0] i_ch    = 8'h00;
    logic [3:0] i_fg    = 4'h0;
    logic [3:0] i_bg    = 4'h0;
    logic [4:0] i_row   = 5'd0;
    logic [6:0] i_col   = 7'd0;
    logic       i_pop   = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [4:0] o_cursor_row;
    logic [6:0] o_cursor_col;
    logic [7:0] o_cell_char;
    logic [7:0] o_cell_attr;
    logic       o_scrolled;

    console_scoreboard sb = new();
    t_console_item     script_items [$];
    int unsigned       cycle_count = 0;

    text_console_writer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_op         (i_op),
        .i_ch         (i_ch),
        .i_fg         (i_fg),
        .i_bg         (i_bg),
        .i_row        (i_row),
        .i_col        (i_col),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_scrolled   (o_scrolled)
    );

    always #2 i_clk = ~i_clk;

    // Bound the run; a hang anywhere ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Push side: every item taken by the block goes through the model here.
    always @(posedge i_clk) begin
        if (i_rst_n && i_push && !o_full)
            sb.note_item(item_of(t_op'(i_op), i_ch, i_fg, i_bg, i_row, i_col));
    end

    // Pop side: every result taken is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty)
            sb.check_result('{cursor_row: o_cursor_row, cursor_col: o_cursor_col,
                              cell_char: o_cell_char, cell_attr: o_cell_attr,
                              scrolled: o_scrolled});
    end

    // Offer one item and hold it until the block takes it.
    task automatic push_item(input t_console_item it);
        i_push <= 1'b1;
        i_op   <= it.op;
        i_ch   <= it.ch;
        i_fg   <= it.fg;
        i_bg   <= it.bg;
        i_row  <= it.row;
        i_col  <= it.col;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
    endtask

    task automatic idle_for(input int unsigned cycles);
        i_push <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop offering and wait until every promised result has been popped.
    task automatic drain_results();
        i_push <= 1'b0;
        do @(posedge i_clk); while (sb.waiting() != 0);
    endtask

    // All fields random; callers override what the item needs.
    function automatic t_console_item random_fields(t_op op);
        return item_of(op, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                       7'($urandom_range(0, 127)));
    endfunction

    function automatic t_console_item printable_put(logic [3:0] fg, logic [3:0] bg);
        t_console_item it;
        it = random_fields(OP_PUT);
        if (it.ch == NEWLINE_CHAR)
            it.ch = it.ch ^ 8'h01;
        it.fg = fg;
        it.bg = bg;
        return it;
    endfunction

    function automatic t_console_item newline_put();
        t_console_item it;
        it    = random_fields(OP_PUT);
        it.ch = NEWLINE_CHAR;
        return it;
    endfunction

    function automatic void queue_full_row();
        for (int i = 0; i < COLUMNS; i++)
            script_items.push_back(printable_put(4'($urandom_range(0, 15)),
                                                 4'($urandom_range(0, 15))));
    endfunction

    function automatic void queue_newlines(int unsigned count);
        repeat (count) script_items.push_back(newline_put());
    endfunction

    // Append one random sequence: mostly text lines and reads back, with wraps,
    // scrolls, clears and out-of-range or unused-op noise mixed in.
    function automatic void refill_script();
        t_console_item it;
        int unsigned   pick;
        logic [3:0]    fg;
        logic [3:0]    bg;
        pick = $urandom_range(0, 99);
        fg   = 4'($urandom_range(0, 15));
        bg   = 4'($urandom_range(0, 15));
        if (pick < 38) begin
            repeat ($urandom_range(1, 30)) script_items.push_back(printable_put(fg, bg));
            script_items.push_back(newline_put());
        end else if (pick < 46) begin
            queue_full_row();
        end else if (pick < 56) begin
            queue_newlines($urandom_range(1, 26));
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 8)) begin
                it = random_fields(OP_READ);
                if ($urandom_range(0, 99) >= 15) begin
                    it.row = 5'($urandom_range(0, ROWS - 1));
                    it.col = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 15))
                                                         : 7'($urandom_range(0, COLUMNS - 1));
                end
                script_items.push_back(it);
            end
        end else if (pick < 96) begin
            repeat ($urandom_range(1, 3)) script_items.push_back(random_fields(OP_NONE));
        end else begin
            script_items.push_back(random_fields(OP_CLEAR));
        end
    endfunction

    // Hit field extremes, every op and the boundary reads before going random.
    task automatic send_directed();
        push_item(item_of(OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        push_item(item_of(OP_PUT, 8'h48, 4'h0, 4'h0, 5'd31, 7'd127));
        push_item(item_of(OP_PUT, 8'h00, 4'hF, 4'hF, 5'd0, 7'd0));
        push_item(item_of(OP_PUT, 8'hFF, 4'hA, 4'h5, 5'd21, 7'd85));
        push_item(item_of(OP_READ, 8'hFF, 4'hF, 4'hF, 5'd0, 7'd1));
        push_item(item_of(OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd2));
        push_item(item_of(OP_PUT, NEWLINE_CHAR, 4'h3, 4'hC, 5'd10, 7'd42));
        push_item(item_of(OP_READ, 8'h55, 4'h5, 4'hA, 5'd24, 7'd79));
        push_item(item_of(OP_READ, 8'hAA, 4'hA, 4'h5, 5'd25, 7'd0));
        push_item(item_of(OP_READ, 8'h00, 4'h0, 4'h0, 5'd31, 7'd127));
        push_item(item_of(OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd80));
        push_item(item_of(OP_NONE, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127));
        push_item(item_of(OP_PUT, 8'h7E, 4'h1, 4'h2, 5'd0, 7'd0));
        push_item(item_of(OP_READ, 8'h00, 4'h0, 4'h0, 5'd1, 7'd0));
        push_item(item_of(OP_CLEAR, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127));
        push_item(item_of(OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        push_item(item_of(OP_READ, 8'h00, 4'h0, 4'h0, 5'd1, 7'd0));
    endtask

    // Random part in bursts with gaps; pause once midway until the block drains.
    task automatic send_random(input int unsigned target);
        t_console_item it;
        int unsigned   sent;
        bit            drained_mid;
        sent        = 0;
        drained_mid = 1'b0;
        // Open with a wrap off the right edge and a run of newlines that scrolls.
        queue_full_row();
        queue_newlines(ROWS);
        while (sent < target) begin
            repeat ($urandom_range(1, 40)) begin
                if (script_items.size() == 0)
                    refill_script();
                it = script_items.pop_front();
                push_item(it);
                if (it.op != OP_NONE)
                    sent++;
            end
            if (!drained_mid && sent >= target / 2) begin
                drain_results();
                drained_mid = 1'b1;
            end
            if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 12));
        end
    endtask

    // Receiver: stretches of steady, light and heavy popping, plus one long hold.
    initial begin : result_pacing
        int unsigned pop_pct;
        bit          hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            case ($urandom_range(0, 2))
                0: pop_pct = 100;
                1: pop_pct = 70;
                default: pop_pct = 20;
            endcase
            repeat ($urandom_range(10, 150)) begin
                i_pop <= ($urandom_range(1, 100) <= pop_pct);
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        drain_results();
        send_random(RANDOM_ITEMS);
        drain_results();
        // Let any stray result surface before the verdict.
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_front.sv
sv/tcw_cmd_fifo.sv
sv/tcw_back.sv
sv/text_console_writer.sv
test/tb.sv
